// File: src/sirt_pkg.sv
// Shared constants, control word types and the microcode ROM for the radix text converter.
package sirt_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int DIGIT_SLOTS = 32;
    localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int DIG_IDX_W   = $clog2(DIGIT_SLOTS);
    localparam int DIG_CNT_W   = $clog2(DIGIT_SLOTS + 1);
    localparam int COUNT_W     = 7;
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 6;
    localparam int REM_W       = DIGIT_W + 1;
    localparam int DIV_BITS    = 4;
    localparam int DIV_ITERS   = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_ITERS);
    localparam int CHAR_CODES  = 2 ** CHAR_W;

    localparam logic [CHAR_W-1:0] SYM_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_INIT,
        S_CHK_RD,
        S_CHK_TEST,
        S_CHK_NEXT,
        S_DIV_START,
        S_DIV_WAIT,
        S_DIV_STORE,
        S_SIGN_CHK,
        S_SIGN_EMIT,
        S_BUF_RD,
        S_SYM_RD,
        S_DIG_EMIT,
        S_DIG_NEXT,
        S_DONE
    } step_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_CONVERT,
        C_RADIX_BAD,
        C_SYM_BAD,
        C_IDX_MORE,
        C_DIV_BUSY,
        C_QUOT_NZ,
        C_POS,
        C_OUT_BUSY,
        C_CNT_NZ
    } cond_t;

    typedef struct packed {
        logic  in_open;
        logic  chk_clr;
        logic  chk_rd;
        logic  chk_mark;
        logic  div_start;
        logic  dig_store;
        logic  emit_sign;
        logic  buf_rd;
        logic  sym_rd;
        logic  emit_digit;
        cond_t cond;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic no_convert;
        logic radix_bad;
        logic sym_bad;
        logic idx_more;
        logic div_busy;
        logic quot_nz;
        logic pos;
        logic out_busy;
        logic cnt_nz;
    } stat_t;

    // One control word per step; a hit on cond jumps to target, else fall through.
    function automatic ctl_t ucode_rom(input step_t addr);
        ctl_t w;
        begin
            w        = '0;
            w.cond   = C_NEVER;
            w.target = S_IDLE;
            case (addr)
                S_IDLE:
                begin
                    w.in_open = 1'b1;
                    w.cond    = C_NO_CONVERT;
                    w.target  = S_IDLE;
                end
                S_CHK_INIT:
                begin
                    w.chk_clr = 1'b1;
                    w.cond    = C_RADIX_BAD;
                    w.target  = S_IDLE;
                end
                S_CHK_RD:
                begin
                    w.chk_rd = 1'b1;
                end
                S_CHK_TEST:
                begin
                    w.chk_mark = 1'b1;
                    w.cond     = C_SYM_BAD;
                    w.target   = S_IDLE;
                end
                S_CHK_NEXT:
                begin
                    w.cond   = C_IDX_MORE;
                    w.target = S_CHK_RD;
                end
                S_DIV_START:
                begin
                    w.div_start = 1'b1;
                end
                S_DIV_WAIT:
                begin
                    w.cond   = C_DIV_BUSY;
                    w.target = S_DIV_WAIT;
                end
                S_DIV_STORE:
                begin
                    w.dig_store = 1'b1;
                    w.cond      = C_QUOT_NZ;
                    w.target    = S_DIV_START;
                end
                S_SIGN_CHK:
                begin
                    w.cond   = C_POS;
                    w.target = S_BUF_RD;
                end
                S_SIGN_EMIT:
                begin
                    w.emit_sign = 1'b1;
                    w.cond      = C_OUT_BUSY;
                    w.target    = S_SIGN_EMIT;
                end
                S_BUF_RD:
                begin
                    w.buf_rd = 1'b1;
                end
                S_SYM_RD:
                begin
                    w.sym_rd = 1'b1;
                end
                S_DIG_EMIT:
                begin
                    w.emit_digit = 1'b1;
                    w.cond       = C_OUT_BUSY;
                    w.target     = S_DIG_EMIT;
                end
                S_DIG_NEXT:
                begin
                    w.cond   = C_CNT_NZ;
                    w.target = S_BUF_RD;
                end
                S_DONE:
                begin
                    w.cond   = C_ALWAYS;
                    w.target = S_IDLE;
                end
                default:
                begin
                    w.cond   = C_ALWAYS;
                    w.target = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// File: src/signed_integer_to_custom_radix_text.sv
// Top level of the signed integer to loadable-radix text converter.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+---------------------------
//  input   | command, symbol_index, symbol_code, value      | in_valid / in_stall
//  output  | out_char, last                                 | out_valid / out_stall
//  config  | cfg_data (symbol_count, the radix)             | cfg_valid / cfg_ready
//
// A load beat writes one alphabet entry. A convert beat runs the microcode:
// an alphabet check, then per digit a division (start, a divider pass that
// retires four quotient bits per cycle, a wait step to see it idle, store),
// then a minus sign for a negative value and the digits, each read back and
// emitted; the output can stall the emit steps. The alphabet check reads the
// symbols in turn through its read, test and next steps and drops the beat
// early on a bad radix or symbol.
// Reset clears the radix, the step counter and the output valid; the
// alphabet is undefined until loaded. in_stall stays high after the last
// character enters the output register until the program steps back to
// idle; the output register holds the character while out_stall is high.
module signed_integer_to_custom_radix_text
    import sirt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [5:0]                symbol_index,
    input  logic [7:0]                symbol_code,
    input  logic signed [31:0]        value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_char,
    output logic                      last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [6:0]                cfg_data
);

    ctl_t  ctl;
    stat_t stat;

    sirt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    sirt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .in_valid     (in_valid),
        .command      (command),
        .symbol_index (symbol_index),
        .symbol_code  (symbol_code),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_char     (out_char),
        .last         (last)
    );

    // Accept input beats only on the idle step of the program.
    assign in_stall  = !ctl.in_open;
    // The radix register takes a write in any cycle.
    assign cfg_ready = 1'b1;

endmodule

// File: src/sirt_div.sv
// Iterative unsigned divider: 32-bit dividend by the radix, four quotient bits per cycle.
module sirt_div
    import sirt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [VALUE_W-1:0]   dividend,
    input  logic [COUNT_W-1:0]   divisor,
    output logic                 busy,
    output logic [VALUE_W-1:0]   quotient,
    output logic [DIGIT_W-1:0]   remainder
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] iter_reg;
    logic [VALUE_W-1:0]   quo_reg;
    logic [VALUE_W-1:0]   quo_next;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;

    // Restoring steps; the partial remainder stays below twice the divisor.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            rem_next = {rem_next[REM_W-2:0], quo_next[VALUE_W-1]};
            quo_next = {quo_next[VALUE_W-2:0], 1'b0};
            if (rem_next >= divisor)
            begin
                rem_next    = rem_next - divisor;
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == DIV_CNT_W'(DIV_ITERS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIGIT_W-1:0];

endmodule

// File: src/sirt_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jump.
module sirt_seq
    import sirt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctl_t  ctl
);

    step_t upc_reg;
    step_t upc_next;
    ctl_t  word;
    logic  hit;

    assign word = ucode_rom(upc_reg);

    always_comb
    begin
        case (word.cond)
            C_NEVER:      hit = 1'b0;
            C_ALWAYS:     hit = 1'b1;
            C_NO_CONVERT: hit = stat.no_convert;
            C_RADIX_BAD:  hit = stat.radix_bad;
            C_SYM_BAD:    hit = stat.sym_bad;
            C_IDX_MORE:   hit = stat.idx_more;
            C_DIV_BUSY:   hit = stat.div_busy;
            C_QUOT_NZ:    hit = stat.quot_nz;
            C_POS:        hit = stat.pos;
            C_OUT_BUSY:   hit = stat.out_busy;
            C_CNT_NZ:     hit = stat.cnt_nz;
            default:      hit = 1'b1;
        endcase
    end

    always_comb
    begin
        if (hit)
        begin
            upc_next = word.target;
        end
        else
        begin
            upc_next = step_t'(upc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctl = word;

endmodule

// File: src/sirt_dp.sv
// Datapath: alphabet and digit memories, check and digit counters, divider, output register.
module sirt_dp
    import sirt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    output stat_t               stat,
    input  logic                in_valid,
    input  logic                command,
    input  logic [SYM_IDX_W-1:0] symbol_index,
    input  logic [CHAR_W-1:0]   symbol_code,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                cfg_valid,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [CHAR_W-1:0]   out_char,
    output logic                last
);

    logic [CHAR_W-1:0]    alpha_mem [MAX_SYMBOLS];
    logic [DIGIT_W-1:0]   buf_mem [DIGIT_SLOTS];

    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   idx_reg;
    logic [DIG_CNT_W-1:0] cnt_reg;
    logic [DIG_CNT_W-1:0] cnt_dec;
    logic [CHAR_CODES-1:0] seen_reg;
    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_in;
    logic                 neg_reg;
    logic [CHAR_W-1:0]    rd_reg;
    logic [SYM_IDX_W-1:0] rd_addr;
    logic [DIGIT_W-1:0]   dig_reg;

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic                 last_reg;
    logic                 out_free;
    logic                 load_out;

    logic                 accept;
    logic                 div_busy;
    logic [VALUE_W-1:0]   div_quo;
    logic [DIGIT_W-1:0]   div_rem;

    assign accept  = ctl.in_open && in_valid;
    assign mag_in  = value[VALUE_W-1] ? (~value + 1'b1) : value;
    assign cnt_dec = cnt_reg - 1'b1;
    assign rd_addr = ctl.sym_rd ? dig_reg[SYM_IDX_W-1:0] : idx_reg[SYM_IDX_W-1:0];

    sirt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (mag_reg),
        .divisor   (count_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Radix register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    // Alphabet memory: load beats write, check and emit steps read.
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_LOAD)
        begin
            alpha_mem[symbol_index] <= symbol_code;
        end
        if (ctl.chk_rd || ctl.sym_rd)
        begin
            rd_reg <= alpha_mem[rd_addr];
        end
    end

    // Digit memory, least significant digit first.
    always_ff @(posedge clk)
    begin
        if (ctl.dig_store)
        begin
            buf_mem[cnt_reg[DIG_IDX_W-1:0]] <= div_rem;
        end
        if (ctl.buf_rd)
        begin
            dig_reg <= buf_mem[cnt_dec[DIG_IDX_W-1:0]];
        end
    end

    // Magnitude and sign of the value under conversion.
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_CONVERT)
        begin
            mag_reg <= mag_in;
            neg_reg <= value[VALUE_W-1];
        end
        else if (ctl.dig_store)
        begin
            mag_reg <= div_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            seen_reg <= '0;
        end
        else
        begin
            if (ctl.chk_clr)
            begin
                idx_reg  <= '0;
                cnt_reg  <= '0;
                seen_reg <= '0;
            end
            else
            begin
                if (ctl.chk_mark)
                begin
                    idx_reg          <= idx_reg + 1'b1;
                    seen_reg[rd_reg] <= 1'b1;
                end
                if (ctl.dig_store)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else if (ctl.buf_rd)
                begin
                    cnt_reg <= cnt_dec;
                end
            end
        end
    end

    // Output register: hold while stalled, take a new beat when it drains.
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (ctl.emit_sign || ctl.emit_digit) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_char_reg <= ctl.emit_sign ? SYM_MINUS : rd_reg;
            last_reg     <= ctl.emit_digit && (cnt_reg == '0);
        end
    end

    assign stat.no_convert = !(accept && command == CMD_CONVERT);
    assign stat.radix_bad  = (count_reg < COUNT_W'(2)) || (32'(count_reg) > MAX_SYMBOLS);
    assign stat.sym_bad    = (rd_reg == SYM_NUL) || (rd_reg == SYM_PLUS)
                             || (rd_reg == SYM_MINUS) || seen_reg[rd_reg];
    assign stat.idx_more   = idx_reg < count_reg;
    assign stat.div_busy   = div_busy;
    assign stat.quot_nz    = div_quo != '0;
    assign stat.pos        = !neg_reg;
    assign stat.out_busy   = !out_free;
    assign stat.cnt_nz     = cnt_reg != '0;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// File: src/sirt_chk.sv
// Port-level checker for the radix text converter, bound to the top level.
module sirt_chk
    import sirt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               command,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         out_char,
    input logic               last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output beat changed while stalled");

    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_CONVERT |=> in_stall)
        else $error("input open right after a convert beat");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == SYM_MINUS |-> !last)
        else $error("sign character marked last");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_char != SYM_NUL && out_char != SYM_PLUS)
        else $error("illegal character emitted");

endmodule

bind signed_integer_to_custom_radix_text sirt_chk u_sirt_chk (.*);

// File: tb/tb_signed_integer_to_custom_radix_text.sv
// Self-checking testbench for the signed integer to loadable-radix text converter.
`timescale 1ns / 1ps

module tb_signed_integer_to_custom_radix_text;
    import sirt_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    // A conversion can still be running its alphabet check after the last
    // character came out (or gave none); a full check reads all 64 symbols.
    localparam int SETTLE_CYCLES = 300;

    // One beat on the command channel.
    typedef struct {
        logic               command;
        logic [5:0]         symbol_index;
        logic [7:0]         symbol_code;
        logic signed [31:0] value;
    } cmd_beat_t;

    // One beat on the text channel.
    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } char_beat_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               command      = CMD_LOAD;
    logic [5:0]         symbol_index = '0;
    logic [7:0]         symbol_code  = '0;
    logic signed [31:0] value        = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [7:0]         out_char;
    logic               last;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [6:0]         cfg_data     = '0;

    // Commands waiting for the driver, and characters waiting for the DUT.
    cmd_beat_t  cmd_queue[$];
    char_beat_t expected_chars[$];
    cmd_beat_t  beat_now;
    char_beat_t char_want;

    // Predictor state: what the DUT should hold after every accepted beat.
    logic [7:0] alpha_copy[MAX_SYMBOLS];
    logic [6:0] radix_copy = '0;

    // Generator view of the alphabet, kept one step ahead of the predictor
    // so that stimulus can be shaped (no read of a never-loaded entry).
    logic [7:0] gen_table[MAX_SYMBOLS];
    bit         gen_written[MAX_SYMBOLS];
    int         radix_set = 0;

    int beats_queued  = 0;
    int beats_taken   = 0;
    int errors        = 0;
    int cycle_count   = 0;
    int send_idle_pct = 19;
    int recv_idle_pct = 75;

    signed_integer_to_custom_radix_text DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .symbol_index (symbol_index),
        .symbol_code  (symbol_code),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung DUT or a lost character ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("signed_integer_to_custom_radix_text test failed");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Radix in range, no zero, plus or minus symbol, no repeated symbol.
    function automatic bit alphabet_usable();
        if (radix_copy < 2 || radix_copy > MAX_SYMBOLS)
            return 1'b0;
        for (int a = 0; a < radix_copy; a++)
        begin
            if (alpha_copy[a] == SYM_NUL || alpha_copy[a] == SYM_PLUS ||
                alpha_copy[a] == SYM_MINUS)
                return 1'b0;
            for (int b = a + 1; b < radix_copy; b++)
                if (alpha_copy[b] == alpha_copy[a])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Apply one accepted beat and queue the characters it must produce.
    function automatic void predict_text(input cmd_beat_t beat);
        logic [32:0] mag;
        logic [5:0]  digits[$];
        char_beat_t  c;
        if (beat.command == CMD_LOAD)
        begin
            alpha_copy[beat.symbol_index] = beat.symbol_code;
            return;
        end
        if (!alphabet_usable())
            return;
        // 33-bit magnitude keeps the most negative value exact.
        mag = beat.value[31] ? ({1'b0, ~beat.value} + 33'd1) : {1'b0, beat.value};
        if (beat.value[31])
        begin
            c.code    = SYM_MINUS;
            c.is_last = 1'b0;
            expected_chars.push_back(c);
        end
        // Zero still yields one digit.
        do
        begin
            digits.push_front(6'(mag % 33'(radix_copy)));
            mag = mag / 33'(radix_copy);
        end
        while (mag != 0);
        for (int k = 0; k < digits.size(); k++)
        begin
            c.code    = alpha_copy[digits[k]];
            c.is_last = (k == digits.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    //------------------------------------------------------------------
    // Driver: present queued commands, predict on each accepted beat
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Sampled values are from before this edge, so this is the beat
            // the DUT just took.
            if (in_valid && !in_stall)
            begin
                predict_text(beat_now);
                beats_taken++;
            end
            // Hold the payload while stalled; otherwise advance or idle.
            if (!in_valid || !in_stall)
            begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_now     = cmd_queue.pop_front();
                    in_valid     <= 1'b1;
                    command      <= beat_now.command;
                    symbol_index <= beat_now.symbol_index;
                    symbol_code  <= beat_now.symbol_code;
                    value        <= beat_now.value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: check each accepted character against the oldest expectation
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: char expected none, actual %h last %b",
                             $time, out_char, last);
                    errors++;
                end
                else
                begin
                    char_want = expected_chars.pop_front();
                    if (out_char !== char_want.code)
                    begin
                        $display("%0t: out_char expected %h, actual %h",
                                 $time, char_want.code, out_char);
                        errors++;
                    end
                    if (last !== char_want.is_last)
                    begin
                        $display("%0t: last expected %b, actual %b",
                                 $time, char_want.is_last, last);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Number of alphabet entries the current radix makes the check read.
    function automatic int checked_span();
        if (radix_set < 2 || radix_set > MAX_SYMBOLS)
            return 0;
        return radix_set;
    endfunction

    // Legal symbol not used by any other entry in the checked span.
    function automatic logic [7:0] unique_code(input int excl);
        logic [7:0] c;
        bit         clash;
        do
        begin
            c     = 8'($urandom_range(1, 255));
            clash = (c == SYM_PLUS) || (c == SYM_MINUS);
            for (int j = 0; j < checked_span(); j++)
                if (j != excl && gen_written[j] && gen_table[j] == c)
                    clash = 1'b1;
        end
        while (clash);
        return c;
    endfunction

    function automatic logic signed [31:0] random_value();
        logic signed [31:0] v;
        int unsigned        pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            case ($urandom_range(4))
                0:       v = 32'sd0;
                1:       v = -32'sd1;
                2:       v = 32'sd1;
                3:       v = 32'h7FFF_FFFF;
                default: v = 32'h8000_0000;
            endcase
        end
        else if (pick < 40)
        begin
            v = 32'($urandom_range(300));
            if ($urandom_range(1))
                v = -v;
        end
        else
        begin
            v = $urandom;
        end
        return v;
    endfunction

    task automatic push_beat(input logic cmd, input logic [5:0] idx,
                             input logic [7:0] code, input logic signed [31:0] val);
        cmd_beat_t b;
        b.command      = cmd;
        b.symbol_index = idx;
        b.symbol_code  = code;
        b.value        = val;
        cmd_queue.push_back(b);
        beats_queued++;
    endtask

    task automatic load_symbol(input int idx, input logic [7:0] code);
        gen_table[idx]   = code;
        gen_written[idx] = 1'b1;
        push_beat(CMD_LOAD, 6'(idx), code, random_value());
    endtask

    // Fill any never-loaded entry the check would read before converting.
    task automatic convert(input logic signed [31:0] val);
        for (int i = 0; i < checked_span(); i++)
            if (!gen_written[i])
                load_symbol(i, unique_code(i));
        push_beat(CMD_CONVERT, 6'($urandom_range(63)), 8'($urandom_range(255)), val);
    endtask

    task automatic fresh_alphabet();
        for (int i = 0; i < checked_span(); i++)
            load_symbol(i, unique_code(i));
    endtask

    // Block until every queued beat is taken and every character checked.
    task automatic wait_drained();
        while (!(beats_taken == beats_queued && expected_chars.size() == 0))
            @(posedge clk);
    endtask

    // Write the radix only once the DUT has gone quiet.
    task automatic set_radix(input int r);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= 7'(r);
        do
            @(posedge clk);
        while (!cfg_ready);
        radix_copy = 7'(r);
        radix_set  = r;
        cfg_valid <= 1'b0;
    endtask

    // Mostly conversions on a good alphabet, plus harmless rewrites, loads
    // outside the checked span, and break-then-repair sequences.
    task automatic random_chunk(input int n);
        int          pick;
        int          span;
        int          idx;
        logic [7:0]  old_code;
        logic [7:0]  bad_code;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            span = checked_span();
            if (pick < 65)
            begin
                convert(random_value());
            end
            else if (pick < 90 && span >= 2)
            begin
                if (pick < 78 && span < MAX_SYMBOLS)
                    load_symbol($urandom_range(span, MAX_SYMBOLS - 1), 8'($urandom_range(255)));
                else
                begin
                    idx = $urandom_range(span - 1);
                    load_symbol(idx, unique_code(idx));
                end
            end
            else if (span >= 2)
            begin
                idx      = $urandom_range(span - 1);
                old_code = gen_table[idx];
                case ($urandom_range(3))
                    0:       bad_code = SYM_NUL;
                    1:       bad_code = SYM_PLUS;
                    2:       bad_code = SYM_MINUS;
                    default: bad_code = gen_table[(idx + 1) % span];
                endcase
                load_symbol(idx, bad_code);
                convert(random_value());
                if ($urandom_range(1))
                    convert(random_value());
                load_symbol(idx, old_code);
            end
            else
            begin
                // Radix out of range: any load, alphabet is never read.
                load_symbol($urandom_range(MAX_SYMBOLS - 1), 8'($urandom_range(255)));
            end
            // Hold the sender until the text pipe is empty now and then.
            if (k == n / 2 || $urandom_range(19) == 0)
                wait_drained();
        end
    endtask

    function automatic int pick_radix();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(2, 16);
        if (pick < 90)
            return $urandom_range(17, MAX_SYMBOLS);
        if (pick < 95)
            return $urandom_range(1);
        return $urandom_range(MAX_SYMBOLS + 1, 127);
    endfunction

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            alpha_copy[i]  = '0;
            gen_table[i]   = '0;
            gen_written[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Radix 0 after reset and radix 1: the check rejects before reading.
        convert(32'sd0);
        set_radix(1);
        convert(32'sd5);

        // Decimal alphabet: zero, signs and both ends of the value range.
        set_radix(10);
        for (int i = 0; i < 10; i++)
            load_symbol(i, 8'h30 + 8'(i));
        convert(32'sd0);
        convert(-32'sd1);
        convert(32'sd7);
        convert(32'h7FFF_FFFF);
        convert(32'h8000_0000);

        // Each way of spoiling the alphabet, then repair it.
        load_symbol(3, SYM_PLUS);
        convert(32'sd42);
        load_symbol(3, SYM_MINUS);
        convert(32'sd42);
        load_symbol(3, SYM_NUL);
        convert(32'sd42);
        load_symbol(3, 8'h30);
        convert(32'sd42);
        load_symbol(3, 8'h33);
        convert(-32'sd903);
        // Top index, outside the symbols in use.
        load_symbol(63, 8'hFF);

        // Smallest radix: the most negative value gives the longest text.
        set_radix(2);
        load_symbol(0, 8'h30);
        load_symbol(1, 8'h31);
        convert(32'h8000_0000);
        convert(32'h7FFF_FFFF);
        convert(-32'sd2);

        // Largest radix.
        set_radix(MAX_SYMBOLS);
        fresh_alphabet();
        convert(32'h8000_0000);
        convert(32'h7FFF_FFFF);
        convert(32'sd63);
        convert(-32'sd64);

        // Oversized radix, including the top register value.
        set_radix(MAX_SYMBOLS + 1);
        convert(32'sd1);
        set_radix(127);
        convert(-32'sd1);

        // Random part in three idling regimes.
        for (int mode = 0; mode < 3; mode++)
        begin
            wait_drained();
            send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 75 : 0;
            recv_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 19 : 0;
            set_radix(pick_radix());
            fresh_alphabet();
            random_chunk(5);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_chars.size() == 0)
            $display("signed_integer_to_custom_radix_text test passed");
        else
            $display("signed_integer_to_custom_radix_text test failed");
        $finish;
    end

endmodule
